// File: sv/rbbm_pkg.sv
// Shared types, widths and codes of the replication backlog block manager.
package rbbm_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W      = 2;
  localparam int FEED_W      = 20;
  localparam int TRIM_W      = 7;
  localparam int OFS_W       = 48;
  localparam int LIMIT_W     = 40;
  localparam int HIST_OUT_W  = 27;
  localparam int CNT_OUT_W   = 7;
  localparam int REF_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 48;

  // Defaults of the top-level parameters
  localparam int CHUNK_BYTES_DEF = 16384;
  localparam int RING_BLOCKS_DEF = 64;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = LIMIT_W'(16384);
  localparam logic [OFS_W-1:0]   INIT_OFS_RST = OFS_W'(1000);

  // Saturation points of the reported counts
  localparam logic [HIST_OUT_W-1:0] HIST_OUT_MAX = '1;
  localparam logic [CNT_OUT_W-1:0]  CNT_OUT_MAX  = '1;
  localparam logic [REF_W-1:0]      REF_MAX      = '1;
  localparam logic [REF_W-1:0]      REF_ONE      = REF_W'(1);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_FEED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRIM  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_OFS = 1'd1;

  // One result item
  typedef struct packed {
    logic                  status;
    logic [TRIM_W-1:0]     blocks_trimmed;
    logic                  in_range;
    logic [OFS_W-1:0]      first_byte_offset;
    logic [OFS_W-1:0]      current_offset;
    logic [HIST_OUT_W-1:0] history_bytes;
    logic [CNT_OUT_W-1:0]  block_count;
    logic [REF_W-1:0]      head_references;
  } res_t;

endpackage

// File: sv/replication_backlog_block_manager.sv
// Top level of the replication backlog block manager: ring descriptor RAM, sequencer, result register.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------------
//   in_      | in_valid / in_ready   | kind, feed_length, trim_limit, resume_offset
//   out_     | out_valid / out_ready | status, blocks_trimmed, in_range, offsets, counts
//   cfg_     | cfg_write_en          | cfg_index, cfg_data
//
// Steps per item: reference, query and a feed that fits the tail block or is refused pass
// through EXEC and DONE; a feed that opens a block adds FEED2; a trim loops in TRIM (one head
// descriptor read-modify-write per cycle, one read and one write port on the descriptor RAM).
// Reset is synchronous; descriptors need no clearing pass, slots are written before read.
// A result waits in the output register; the sequencer stalls only if it is still occupied.
module replication_backlog_block_manager import rbbm_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int RING_BLOCKS = RING_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [FEED_W-1:0]     in_feed_length,
  input  logic [TRIM_W-1:0]     in_trim_limit,
  input  logic [OFS_W-1:0]      in_resume_offset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_status,
  output logic [TRIM_W-1:0]     out_blocks_trimmed,
  output logic                  out_in_range,
  output logic [OFS_W-1:0]      out_first_byte_offset,
  output logic [OFS_W-1:0]      out_current_offset,
  output logic [HIST_OUT_W-1:0] out_history_bytes,
  output logic [CNT_OUT_W-1:0]  out_block_count,
  output logic [REF_W-1:0]      out_head_references,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Block capacity covers the largest feed or one chunk
  localparam int FEED_MAX = (1 << FEED_W) - 1;
  localparam int CAP_MAX  = (CHUNK_BYTES > FEED_MAX) ? CHUNK_BYTES : FEED_MAX;
  localparam int CAP_W    = $clog2(CAP_MAX + 1);
  localparam int SLOT_W   = $clog2(RING_BLOCKS);
  localparam int ENT_W    = 2 * CAP_W + REF_W;

  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic              out_free, res_load;
  res_t              res;

  // Descriptor store: {capacity, fill, references} per slot
  rbbm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_BLOCKS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rbbm_core #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .RING_BLOCKS (RING_BLOCKS),
    .CAP_W       (CAP_W),
    .SLOT_W      (SLOT_W),
    .ENT_W       (ENT_W)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_feed_length   (in_feed_length),
    .in_trim_limit    (in_trim_limit),
    .in_resume_offset (in_resume_offset),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_free         (out_free),
    .res_load         (res_load),
    .res              (res)
  );

  rbbm_out u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (res_load),
    .res_in                (res),
    .out_free              (out_free),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_blocks_trimmed    (out_blocks_trimmed),
    .out_in_range          (out_in_range),
    .out_first_byte_offset (out_first_byte_offset),
    .out_current_offset    (out_current_offset),
    .out_history_bytes     (out_history_bytes),
    .out_block_count       (out_block_count),
    .out_head_references   (out_head_references)
  );

endmodule

// File: sv/rbbm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rbbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rbbm_out.sv
// Result register: holds one finished result until the output transfer.
module rbbm_out import rbbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  res_t                  res_in,
  output logic                  out_free,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [TRIM_W-1:0]     out_blocks_trimmed,
  output logic                  out_in_range,
  output logic [OFS_W-1:0]      out_first_byte_offset,
  output logic [OFS_W-1:0]      out_current_offset,
  output logic [HIST_OUT_W-1:0] out_history_bytes,
  output logic [CNT_OUT_W-1:0]  out_block_count,
  output logic [REF_W-1:0]      out_head_references
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // Slot is free when empty or being drained this cycle
  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid             = valid_r;
  assign out_status            = res_r.status;
  assign out_blocks_trimmed    = res_r.blocks_trimmed;
  assign out_in_range          = res_r.in_range;
  assign out_first_byte_offset = res_r.first_byte_offset;
  assign out_current_offset    = res_r.current_offset;
  assign out_history_bytes     = res_r.history_bytes;
  assign out_block_count       = res_r.block_count;
  assign out_head_references   = res_r.head_references;

endmodule

// File: sv/rbbm_core.sv
// Sequencer: reads, updates and writes back block descriptors in the ring RAM.
module rbbm_core import rbbm_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int RING_BLOCKS = RING_BLOCKS_DEF,
  parameter int CAP_W       = 20,
  parameter int SLOT_W      = 6,
  parameter int ENT_W       = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [FEED_W-1:0]     in_feed_length,
  input  logic [TRIM_W-1:0]     in_trim_limit,
  input  logic [OFS_W-1:0]      in_resume_offset,
  // configuration writes
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // descriptor RAM
  output logic                  ram_we,
  output logic [SLOT_W-1:0]     ram_waddr,
  output logic [ENT_W-1:0]      ram_wdata,
  output logic                  ram_re,
  output logic [SLOT_W-1:0]     ram_raddr,
  input  logic [ENT_W-1:0]      ram_rdata,
  // result register
  input  logic                  out_free,
  output logic                  res_load,
  output res_t                  res
);

  localparam int CNT_W  = $clog2(RING_BLOCKS + 1);
  localparam int HIST_W = CAP_W + SLOT_W;
  localparam int CMP_W  = (HIST_W > LIMIT_W) ? HIST_W : LIMIT_W;
  localparam int HX_W   = (HIST_W > HIST_OUT_W) ? HIST_W : HIST_OUT_W;
  localparam int CX_W   = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FEED2 = 3'd2;
  localparam logic [2:0] S_TRIM  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Control state
  logic [2:0]         state_r, state_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [SLOT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [HIST_W-1:0]  hist_r, hist_nxt;
  logic [OFS_W-1:0]   master_r, master_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [REF_W-1:0]   head_refs_r, head_refs_nxt;
  logic [TRIM_W-1:0]  dropped_r, dropped_nxt;
  logic               trim_inc_r, trim_inc_nxt;
  logic               status_r, status_nxt;
  logic               inr_r, inr_nxt;
  logic [FEED_W-1:0]  rem_r, rem_nxt;

  // Latched item payload
  logic [KIND_W-1:0]  kind_r;
  logic [FEED_W-1:0]  flen_r;
  logic [TRIM_W-1:0]  tlim_r;
  logic [OFS_W-1:0]   resume_r;

  // Descriptor fields of the read word
  logic [CAP_W-1:0]   rd_cap, rd_fill;
  logic [REF_W-1:0]   rd_refs, refs_inc, refs_eff;

  // Feed datapath
  logic [CAP_W-1:0]   room, flen_c, take, rem, new_cap;
  logic               refuse;
  logic [SLOT_W-1:0]  head_next, tail_next, new_slot;

  // Trim datapath
  logic [HIST_W-1:0]  hist_less;
  logic               drop;

  // Query datapath
  logic [OFS_W:0]     m_plus1, resume_hist;

  // Result formatting
  logic [HX_W-1:0]    hist_x;
  logic [CX_W-1:0]    held_x;

  logic accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign rd_cap  = ram_rdata[ENT_W-1 -: CAP_W];
  assign rd_fill = ram_rdata[REF_W +: CAP_W];
  assign rd_refs = ram_rdata[REF_W-1:0];

  // Saturating reference increment; trim raises the new head's count on its first visit
  assign refs_inc = (rd_refs == REF_MAX) ? rd_refs : rd_refs + 1'b1;
  assign refs_eff = trim_inc_r ? refs_inc : rd_refs;

  // Ring successor slots
  assign head_next = (head_r == SLOT_W'(RING_BLOCKS - 1)) ? '0 : head_r + 1'b1;
  assign tail_next = (tail_r == SLOT_W'(RING_BLOCKS - 1)) ? '0 : tail_r + 1'b1;
  assign new_slot  = (held_r == '0) ? head_r : tail_next;

  // Feed split: free room in the tail block, then the rest opens a new block
  assign room    = (held_r != '0) ? rd_cap - rd_fill : '0;
  assign flen_c  = CAP_W'(flen_r);
  assign take    = (room < flen_c) ? room : flen_c;
  assign rem     = flen_c - take;
  assign refuse  = (rem != '0) && (held_r == CNT_W'(RING_BLOCKS));
  assign new_cap = (CAP_W'(rem_r) > CAP_W'(CHUNK_BYTES)) ? CAP_W'(rem_r)
                                                        : CAP_W'(CHUNK_BYTES);

  // Head drop test
  assign hist_less = hist_r - HIST_W'(rd_fill);
  assign drop = (CMP_W'(hist_r) > CMP_W'(limit_r)) && (dropped_r < tlim_r) &&
                (held_r > CNT_W'(1)) && (refs_eff == REF_ONE) &&
                (CMP_W'(hist_less) > CMP_W'(limit_r));

  // Resume offset window, exact integers
  assign m_plus1     = {1'b0, master_r} + 1'b1;
  assign resume_hist = {1'b0, resume_r} + (OFS_W+1)'(hist_r);

  // Next state and descriptor writes
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    held_nxt      = held_r;
    hist_nxt      = hist_r;
    master_nxt    = master_r;
    limit_nxt     = limit_r;
    head_refs_nxt = head_refs_r;
    dropped_nxt   = dropped_r;
    trim_inc_nxt  = trim_inc_r;
    status_nxt    = status_r;
    inr_nxt       = inr_r;
    rem_nxt       = rem_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = head_r;
    res_load      = 1'b0;

    // Configuration (the user must write it only while idle; the block does not enforce this)
    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_LIMIT:    limit_nxt  = cfg_data[LIMIT_W-1:0];
        REG_INIT_OFS: master_nxt = cfg_data[OFS_W-1:0];
        default:      ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt   = 1'b0;
          inr_nxt      = 1'b0;
          dropped_nxt  = '0;
          trim_inc_nxt = 1'b0;
          ram_re       = 1'b1;
          ram_raddr    = (in_kind == KIND_FEED) ? tail_r : head_r;
          state_nxt    = (in_kind == KIND_TRIM) ? S_TRIM : S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (kind_r)
          KIND_FEED: begin
            if (refuse) begin
              status_nxt = 1'b1;
            end else begin
              if (take != '0) begin
                ram_we    = 1'b1;
                ram_waddr = tail_r;
                ram_wdata = {rd_cap, rd_fill + take, rd_refs};
              end
              hist_nxt   = hist_r + HIST_W'(flen_r);
              master_nxt = master_r + OFS_W'(flen_r);
              rem_nxt    = FEED_W'(rem);
              if (rem != '0) begin
                state_nxt = S_FEED2;
              end
            end
          end
          KIND_REF: begin
            if (held_r != '0) begin
              ram_we        = 1'b1;
              ram_waddr     = head_r;
              ram_wdata     = {rd_cap, rd_fill, refs_inc};
              head_refs_nxt = refs_inc;
            end
          end
          KIND_TRIM: ;
          KIND_QUERY: begin
            inr_nxt = (resume_hist >= m_plus1) && ({1'b0, resume_r} <= m_plus1);
          end
        endcase
      end

      // Open a new block; the first block of an empty ring carries the backlog's reference
      S_FEED2: begin
        ram_we    = 1'b1;
        ram_waddr = new_slot;
        ram_wdata = {new_cap, CAP_W'(rem_r), (held_r == '0) ? REF_ONE : '0};
        tail_nxt  = new_slot;
        held_nxt  = held_r + 1'b1;
        if (held_r == '0) begin
          head_refs_nxt = REF_ONE;
        end
        state_nxt = S_DONE;
      end

      // One head block per cycle; a dropped head's reference moves to the next one
      S_TRIM: begin
        if (trim_inc_r) begin
          ram_we        = 1'b1;
          ram_waddr     = head_r;
          ram_wdata     = {rd_cap, rd_fill, refs_eff};
          head_refs_nxt = refs_eff;
        end
        if (drop) begin
          hist_nxt     = hist_less;
          head_nxt     = head_next;
          held_nxt     = held_r - 1'b1;
          dropped_nxt  = dropped_r + 1'b1;
          trim_inc_nxt = 1'b1;
          ram_re       = 1'b1;
          ram_raddr    = head_next;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result fields from the state after the step
  always_comb begin
    hist_x = HX_W'(hist_r);
    held_x = CX_W'(held_r);
    res.status            = status_r;
    res.blocks_trimmed    = dropped_r;
    res.in_range          = inr_r;
    res.first_byte_offset = master_r - OFS_W'(hist_r) + 1'b1;
    res.current_offset    = master_r;
    res.history_bytes     = (hist_x > HX_W'(HIST_OUT_MAX)) ? HIST_OUT_MAX
                                                           : HIST_OUT_W'(hist_x);
    res.block_count       = (held_x > CX_W'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                          : CNT_OUT_W'(held_x);
    res.head_references   = (held_r != '0) ? head_refs_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      hist_r      <= '0;
      master_r    <= INIT_OFS_RST;
      limit_r     <= LIMIT_RST;
      head_refs_r <= '0;
      dropped_r   <= '0;
      trim_inc_r  <= 1'b0;
      status_r    <= 1'b0;
      inr_r       <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      hist_r      <= hist_nxt;
      master_r    <= master_nxt;
      limit_r     <= limit_nxt;
      head_refs_r <= head_refs_nxt;
      dropped_r   <= dropped_nxt;
      trim_inc_r  <= trim_inc_nxt;
      status_r    <= status_nxt;
      inr_r       <= inr_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Item payload, captured on the input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      flen_r   <= in_feed_length;
      tlim_r   <= in_trim_limit;
      resume_r <= in_resume_offset;
    end
  end

endmodule

// File: verif/tb_replication_backlog_block_manager.sv
// Self-checking testbench for the replication backlog block manager: ring descriptor prediction.
`timescale 1ns / 100ps

module tb_replication_backlog_block_manager;
  import rbbm_pkg::*;

  localparam int SLOT_W      = $clog2(RING_BLOCKS_DEF);
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 200;
  localparam int DRAIN_WAIT  = 70;

  // Ring descriptor predictor and store of pending reports
  class backlog_scoreboard;
    logic [20:0]        blk_cap [RING_BLOCKS_DEF];
    logic [20:0]        blk_fill[RING_BLOCKS_DEF];
    logic [REF_W-1:0]   blk_refs[RING_BLOCKS_DEF];
    logic [SLOT_W-1:0]  head;
    logic [SLOT_W-1:0]  tail;
    int unsigned        held;
    longint unsigned    history;
    logic [OFS_W-1:0]   master;
    logic [LIMIT_W-1:0] trim_threshold;
    logic [OFS_W-1:0]   start_offset;
    res_t               queued_reports[$];
    int                 errors;

    function new();
      for (int i = 0; i < RING_BLOCKS_DEF; i++) begin
        blk_cap[i]  = '0;
        blk_fill[i] = '0;
        blk_refs[i] = '0;
      end
      head           = '0;
      tail           = '0;
      held           = 0;
      history        = 0;
      trim_threshold = LIMIT_RST;
      start_offset   = INIT_OFS_RST;
      master         = INIT_OFS_RST;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_LIMIT) begin
        trim_threshold = data[LIMIT_W-1:0];
      end else begin
        // offset register also reloads the live offset
        start_offset = data[OFS_W-1:0];
        master       = data[OFS_W-1:0];
      end
    endfunction

    function logic [OFS_W-1:0] first_byte();
      return master - OFS_W'(history) + OFS_W'(1);
    endfunction

    function void bump_ref(logic [SLOT_W-1:0] slot);
      if (blk_refs[slot] != REF_MAX) blk_refs[slot] = blk_refs[slot] + REF_ONE;
    endfunction

    // Apply one item to the ring and build its report
    function res_t advance_ring(logic [KIND_W-1:0] kind, logic [FEED_W-1:0] flen,
                                logic [TRIM_W-1:0] tlim, logic [OFS_W-1:0] resume);
      res_t              rpt;
      int unsigned       room;
      int unsigned       take;
      int unsigned       rem;
      int unsigned       dropped;
      logic [SLOT_W-1:0] slot;
      longint unsigned   top;
      rpt     = '0;
      dropped = 0;
      case (kind)
        KIND_FEED: begin
          if (flen != '0) begin
            room = (held > 0) ? int'(blk_cap[tail]) - int'(blk_fill[tail]) : 0;
            take = (room < flen) ? room : flen;
            rem  = flen - take;
            if (rem > 0 && held >= RING_BLOCKS_DEF) begin
              // ring full: refused whole
              rpt.status = 1'b1;
            end else begin
              if (take > 0) blk_fill[tail] = blk_fill[tail] + 21'(take);
              if (rem > 0) begin
                slot = (held == 0) ? head : SLOT_W'((int'(tail) + 1) % RING_BLOCKS_DEF);
                blk_cap[slot]  = 21'((rem > CHUNK_BYTES_DEF) ? rem : CHUNK_BYTES_DEF);
                blk_fill[slot] = 21'(rem);
                blk_refs[slot] = (held == 0) ? REF_ONE : '0;
                tail = slot;
                held++;
              end
              history += flen;
              master  = master + OFS_W'(flen);
            end
          end
        end
        KIND_REF: begin
          if (held > 0) bump_ref(head);
        end
        KIND_TRIM: begin
          while (history > trim_threshold && dropped < tlim) begin
            if (held <= 1) break;
            if (blk_refs[head] != REF_ONE) break;
            if (history - blk_fill[head] <= trim_threshold) break;
            history -= blk_fill[head];
            head = SLOT_W'((int'(head) + 1) % RING_BLOCKS_DEF);
            held--;
            // dropped head hands its reference on
            bump_ref(head);
            dropped++;
          end
        end
        default: begin
          top = longint'(master) + 1;
          rpt.in_range = (longint'(resume) + history >= top) && (longint'(resume) <= top);
        end
      endcase
      rpt.blocks_trimmed    = TRIM_W'(dropped);
      rpt.first_byte_offset = first_byte();
      rpt.current_offset    = master;
      rpt.history_bytes     = (history > HIST_OUT_MAX) ? HIST_OUT_MAX : HIST_OUT_W'(history);
      rpt.block_count       = (held > CNT_OUT_MAX) ? CNT_OUT_MAX : CNT_OUT_W'(held);
      rpt.head_references   = (held > 0) ? blk_refs[head] : '0;
      return rpt;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [FEED_W-1:0] flen,
                            logic [TRIM_W-1:0] tlim, logic [OFS_W-1:0] resume);
      queued_reports.push_back(advance_ring(kind, flen, tlim, resume));
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_report(res_t got);
      res_t exp_r;
      if (queued_reports.size() == 0) begin
        $error("result transfer with no pending report");
        errors++;
        return;
      end
      exp_r = queued_reports.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("blocks_trimmed", exp_r.blocks_trimmed, got.blocks_trimmed);
      compare_field("in_range", exp_r.in_range, got.in_range);
      compare_field("first_byte_offset", exp_r.first_byte_offset, got.first_byte_offset);
      compare_field("current_offset", exp_r.current_offset, got.current_offset);
      compare_field("history_bytes", exp_r.history_bytes, got.history_bytes);
      compare_field("block_count", exp_r.block_count, got.block_count);
      compare_field("head_references", exp_r.head_references, got.head_references);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind;
  logic [FEED_W-1:0]     in_feed_length;
  logic [TRIM_W-1:0]     in_trim_limit;
  logic [OFS_W-1:0]      in_resume_offset;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_status;
  logic [TRIM_W-1:0]     out_blocks_trimmed;
  logic                  out_in_range;
  logic [OFS_W-1:0]      out_first_byte_offset;
  logic [OFS_W-1:0]      out_current_offset;
  logic [HIST_OUT_W-1:0] out_history_bytes;
  logic [CNT_OUT_W-1:0]  out_block_count;
  logic [REF_W-1:0]      out_head_references;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  backlog_scoreboard sb;
  bit                burst_mode = 1'b0;
  int                stall_cycles = 0;

  replication_backlog_block_manager u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_feed_length        (in_feed_length),
    .in_trim_limit         (in_trim_limit),
    .in_resume_offset      (in_resume_offset),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_blocks_trimmed    (out_blocks_trimmed),
    .out_in_range          (out_in_range),
    .out_first_byte_offset (out_first_byte_offset),
    .out_current_offset    (out_current_offset),
    .out_history_bytes     (out_history_bytes),
    .out_block_count       (out_block_count),
    .out_head_references   (out_head_references),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles without any transfer or config write
  always @(posedge clk) begin
    if (!rst_n || cfg_write_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_replication_backlog_block_manager: errors");
      $finish;
    end
  end

  function automatic logic [OFS_W-1:0] rand_ofs();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Feed lengths: mostly small or chunk-sized, sometimes the full field
  function automatic logic [FEED_W-1:0] rand_feed_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 45) return FEED_W'($urandom_range(1, 3000));
    if (r < 72) return FEED_W'($urandom_range(16000, 17000));
    if (r < 88) return FEED_W'($urandom_range(17000, 200000));
    return FEED_W'($urandom);
  endfunction

  function automatic logic [TRIM_W-1:0] rand_trim_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return TRIM_W'($urandom_range(1, 4));
    if (r < 80) return TRIM_W'($urandom_range(0, 64));
    return TRIM_W'($urandom);
  endfunction

  // Resume offsets around both window edges, inside the window, or anywhere
  function automatic logic [OFS_W-1:0] rand_resume();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return sb.first_byte() + OFS_W'($urandom_range(0, 2)) - OFS_W'(1);
    if (r < 50) return sb.master + OFS_W'($urandom_range(0, 2));
    if (r < 70) return sb.first_byte() + OFS_W'($urandom_range(0, int'(sb.history)));
    return rand_ofs();
  endfunction

  // One input transfer; the payload stays put until accepted
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [FEED_W-1:0] flen,
                           input logic [TRIM_W-1:0] tlim, input logic [OFS_W-1:0] resume);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_feed_length   <= flen;
    in_trim_limit    <= tlim;
    in_resume_offset <= resume;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(kind, flen, tlim, resume);
  endtask

  // Register writes only once every report is back and the block has settled
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] limit_data,
                             input logic [CFG_DATA_W-1:0] ofs_data);
    in_valid <= 1'b0;
    while (sb.queued_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_LIMIT;
    cfg_data     <= limit_data;
    @(posedge clk);
    sb.write_reg(REG_LIMIT, limit_data);
    cfg_index <= REG_INIT_OFS;
    cfg_data  <= ofs_data;
    @(posedge clk);
    sb.write_reg(REG_INIT_OFS, ofs_data);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int feed_pct, input int trim_pct,
                           input int ref_pct);
    int                r;
    logic [KIND_W-1:0] k;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < feed_pct) k = KIND_FEED;
      else if (r < feed_pct + trim_pct) k = KIND_TRIM;
      else if (r < feed_pct + trim_pct + ref_pct) k = KIND_REF;
      else k = KIND_QUERY;
      send_item(k, rand_feed_len(), rand_trim_limit(), rand_resume());
    end
  endtask

  // Result side: random stalls, one long hold-off
  initial begin
    int   gap;
    int   received;
    bit   held_off;
    res_t got;
    received = 0;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && received == HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status            = out_status;
      got.blocks_trimmed    = out_blocks_trimmed;
      got.in_range          = out_in_range;
      got.first_byte_offset = out_first_byte_offset;
      got.current_offset    = out_current_offset;
      got.history_bytes     = out_history_bytes;
      got.block_count       = out_block_count;
      got.head_references   = out_head_references;
      sb.check_report(got);
      received++;
    end
  end

  // Stimulus
  initial begin
    sb = new();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_FEED;
    in_feed_length   <= '0;
    in_trim_limit    <= '0;
    in_resume_offset <= '0;
    cfg_write_en     <= 1'b0;
    cfg_index        <= REG_LIMIT;
    cfg_data         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring: query edges, ignored reference, trim, zero-length feed
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), '0);
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), sb.master + OFS_W'(1));
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), sb.master + OFS_W'(2));
    send_item(KIND_REF, rand_feed_len(), rand_trim_limit(), rand_ofs());
    send_item(KIND_TRIM, rand_feed_len(), TRIM_W'(64), rand_ofs());
    send_item(KIND_FEED, '0, rand_trim_limit(), rand_ofs());
    // first block, fill to capacity, largest feed, chunk feed
    send_item(KIND_FEED, FEED_W'(1), rand_trim_limit(), rand_ofs());
    send_item(KIND_FEED, FEED_W'(16383), rand_trim_limit(), rand_ofs());
    send_item(KIND_FEED, '1, rand_trim_limit(), rand_ofs());
    send_item(KIND_FEED, FEED_W'(16384), rand_trim_limit(), rand_ofs());
    // window edges with history present
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), sb.first_byte());
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), sb.first_byte() - OFS_W'(1));
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), sb.master + OFS_W'(1));
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), '1);
    // trims: zero limit, widest field, normal limit
    send_item(KIND_TRIM, rand_feed_len(), '0, rand_ofs());
    send_item(KIND_TRIM, rand_feed_len(), '1, rand_ofs());
    send_item(KIND_TRIM, rand_feed_len(), TRIM_W'(64), rand_ofs());
    send_item(KIND_FEED, FEED_W'(5000), rand_trim_limit(), rand_ofs());
    send_item(KIND_FEED, FEED_W'(20000), rand_trim_limit(), rand_ofs());
    send_item(KIND_TRIM, rand_feed_len(), TRIM_W'(1), rand_ofs());
    send_item(KIND_QUERY, rand_feed_len(), rand_trim_limit(), '0);

    // random phases; reader references only at the end, since they pin the head
    reconfigure('0, '0);
    run_phase(80, 50, 35, 0);
    reconfigure('1, '1);
    run_phase(80, 75, 10, 0);
    burst_mode = 1'b1;
    reconfigure(CFG_DATA_W'(16384), {OFS_W{1'b1}} - OFS_W'(40000));
    run_phase(80, 50, 35, 0);
    burst_mode = 1'b0;
    reconfigure(CFG_DATA_W'($urandom_range(0, 300000)), rand_ofs());
    run_phase(80, 50, 30, 0);
    reconfigure(CFG_DATA_W'(1), OFS_W'(1000));
    run_phase(80, 45, 40, 0);
    burst_mode = 1'b1;
    reconfigure(rand_ofs(), rand_ofs());
    run_phase(80, 55, 25, 0);
    burst_mode = 1'b0;
    reconfigure(CFG_DATA_W'(60000), rand_ofs());
    run_phase(80, 50, 35, 0);
    // reference saturation, then a feed-heavy random phase that also sends references
    reconfigure(CFG_DATA_W'(16384), OFS_W'(5));
    repeat (260) send_item(KIND_REF, rand_feed_len(), rand_trim_limit(), rand_ofs());
    run_phase(90, 65, 10, 10);

    in_valid <= 1'b0;
    while (sb.queued_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_replication_backlog_block_manager: clean");
    end else begin
      $display("tb_replication_backlog_block_manager: errors");
    end
    $finish;
  end

endmodule

// File: replication_backlog_block_manager.f
sv/rbbm_pkg.sv
sv/rbbm_ram.sv
sv/rbbm_out.sv
sv/rbbm_core.sv
sv/replication_backlog_block_manager.sv
verif/tb_replication_backlog_block_manager.sv
